/* rtl/core/pcpb_pkg.sv */
// Shared types, constants and helpers of the patch column post blitter.
package pcpb_pkg;

	localparam int MAX_DUP = 4;
	localparam int ADDR_W = 24;
	localparam int LW_W = 12;
	localparam int DUP_REG_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int SCOL_W = 10;
	localparam int PIX_W = 8;

	localparam logic [PIX_W-1:0] END_TOP = 8'hff;

	// Clamped replication factor, 1..MAX_DUP
	localparam int DUPN_W = $clog2(MAX_DUP + 1);
	// Scaled column base
	localparam int CB_W = SCOL_W + DUPN_W;
	// Unscaled top row plus scaled row offset
	localparam int ROWS_W = $clog2(255 * (MAX_DUP + 1) + 1);
	// Accumulated copy row offset, dy times line width
	localparam int OFF_W = LW_W + DUPN_W;

	// Command queue, depth must be a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_DUP_X      = 2'd1,
		REG_DUP_Y      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LW_W-1:0]   line_width;
		logic [DUPN_W-1:0] dup_x;
		logic [DUPN_W-1:0] dup_y;
	} cfg_t;

	typedef struct packed {
		logic              is_end;
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] base;
	} cmd_t;

	function automatic logic [DUPN_W-1:0] dup_clamp(input logic [DUP_REG_W-1:0] v);
		logic [DUPN_W-1:0] r;
		if (v == '0) begin
			r = DUPN_W'(1);
		end else if (int'(v) > MAX_DUP) begin
			r = DUPN_W'(MAX_DUP);
		end else begin
			r = DUPN_W'(v);
		end
		return r;
	endfunction

endpackage

/* rtl/core/patch_column_post_blitter_top.sv */
// Patch column post blitter: sprite column post stream in, framebuffer pixel writes out.
// Takes one byte of a column's post stream per transaction and produces pixel writes.
// Header, pad and ignored bytes produce nothing; a data byte yields dup_y rows of dup_x
// writes, one write per cycle while the output is not stalled; the end marker yields a
// single result. The parser runs ahead of the write expander through a four-entry
// command queue, so input stalls only when that queue is full. A byte's first write
// passes the parser's stage register, the command queue and the expander's output
// register. Sustained rate is set by the expander: one result per cycle unless stalled.
module patch_column_post_blitter_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] stream_byte, [17:8] screen_column, [23:18] zero
	input  logic [23:0]                        s_axis_tdata,
	// [0] column_start
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [23:0] write_address, [31:24] write_pixel
	output logic [31:0]                        m_axis_tdata,
	// [0] is_write
	output logic                               m_axis_tuser,
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [pcpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pcpb_pkg::*;

	logic [LW_W-1:0]      line_width_q;
	logic [DUP_REG_W-1:0] dup_x_q;
	logic [DUP_REG_W-1:0] dup_y_q;
	cfg_t                 cfg;

	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_head_valid;
	cmd_t                 q_push_cmd;
	cmd_t                 q_head;

	logic [ADDR_W-1:0]    write_address;
	logic [PIX_W-1:0]     write_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_W'(320);
			dup_x_q <= DUP_REG_W'(1);
			dup_y_q <= DUP_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				REG_DUP_X: dup_x_q <= cfg_data[DUP_REG_W-1:0];
				REG_DUP_Y: dup_y_q <= cfg_data[DUP_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.line_width = line_width_q;
	assign cfg.dup_x = dup_clamp(dup_x_q);
	assign cfg.dup_y = dup_clamp(dup_y_q);

	pcpb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.stream_byte   (s_axis_tdata[7:0]),
		.column_start  (s_axis_tuser),
		.screen_column (s_axis_tdata[17:8]),
		.cfg           (cfg),
		.push          (q_push),
		.push_cmd      (q_push_cmd),
		.full          (q_full)
	);

	pcpb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	pcpb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (q_head),
		.head_valid    (q_head_valid),
		.pop           (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.write_address (write_address),
		.write_pixel   (write_pixel),
		.is_write      (m_axis_tuser),
		.last_of_run   (m_axis_tlast)
	);

	assign m_axis_tdata = {write_pixel, write_address};

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("command popped from empty queue");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
		else $error("end marker not last or not zero");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_axis_tvalid && m_axis_tlast))
		else $error("command retired without a last result");
`endif

endmodule

/* rtl/core/pcpb_front.sv */
// Post stream parser: accepts bytes, tracks the post header and queues write and end commands.
module pcpb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pcpb_pkg::PIX_W-1:0]      stream_byte,
	input  logic                            column_start,
	input  logic [pcpb_pkg::SCOL_W-1:0]     screen_column,
	input  pcpb_pkg::cfg_t                  cfg,
	output logic                            push,
	output pcpb_pkg::cmd_t                  push_cmd,
	input  logic                            full
);
	import pcpb_pkg::*;

	typedef enum logic [5:0] {
		PH_DONE = 6'b000001,
		PH_TOP  = 6'b000010,
		PH_LEN  = 6'b000100,
		PH_PAD1 = 6'b001000,
		PH_DATA = 6'b010000,
		PH_PAD2 = 6'b100000
	} phase_t;

	phase_t             phase_q, phase_eff, phase_nxt;
	logic [PIX_W-1:0]   top_q;
	logic [7:0]         left_q;
	logic [7:0]         rip_q;
	logic [CB_W-1:0]    cb_q;

	logic               v_s1;
	logic               end_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [ROWS_W-1:0]  rows_s1;
	logic [CB_W-1:0]    cb_s1;

	logic               in_fire;
	logic               emit;
	logic               emit_end;
	logic [ROWS_W-1:0]  rows;

	assign in_ready = !v_s1 || !full;
	assign in_fire = in_valid && in_ready;
	assign rows = ROWS_W'(top_q) + ROWS_W'(rip_q) * ROWS_W'(cfg.dup_y);

	always_comb begin
		phase_eff = column_start ? PH_TOP : phase_q;
		phase_nxt = phase_eff;
		emit = 1'b0;
		emit_end = 1'b0;
		case (phase_eff)
			PH_TOP: begin
				if (stream_byte == END_TOP) begin
					emit = 1'b1;
					emit_end = 1'b1;
					phase_nxt = PH_DONE;
				end else begin
					phase_nxt = PH_LEN;
				end
			end
			PH_LEN: phase_nxt = PH_PAD1;
			PH_PAD1: phase_nxt = (left_q != '0) ? PH_DATA : PH_PAD2;
			PH_DATA: begin
				emit = 1'b1;
				if (left_q == 8'd1) begin
					phase_nxt = PH_PAD2;
				end
			end
			PH_PAD2: phase_nxt = PH_TOP;
			default: phase_nxt = phase_eff;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			top_q <= '0;
			left_q <= '0;
			rip_q <= '0;
			cb_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_nxt;
			if (column_start) begin
				cb_q <= CB_W'(screen_column) * CB_W'(cfg.dup_x);
			end
			if (phase_eff == PH_TOP) begin
				top_q <= stream_byte;
			end
			if (phase_eff == PH_LEN) begin
				left_q <= stream_byte;
				rip_q <= '0;
			end
			if (phase_eff == PH_DATA) begin
				left_q <= left_q - 8'd1;
				rip_q <= rip_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			end_s1 <= emit_end;
			pix_s1 <= stream_byte;
			rows_s1 <= rows;
			cb_s1 <= cb_q;
		end
	end

	// Row start address of the first copy: base column plus rows times stride
	assign push = v_s1 && !full;
	assign push_cmd.is_end = end_s1;
	assign push_cmd.pixel = pix_s1;
	assign push_cmd.base = ADDR_W'(cb_s1) + ADDR_W'(rows_s1) * ADDR_W'(cfg.line_width);

endmodule

/* rtl/core/pcpb_queue.sv */
// Short command queue between the parser and the write expander.
module pcpb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcpb_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output pcpb_pkg::cmd_t head,
	output logic           head_valid
);
	import pcpb_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/core/pcpb_back.sv */
// Write expander: turns each queued write command into dup_y by dup_x pixel writes, an end command into one marker.
module pcpb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pcpb_pkg::cfg_t               cfg,
	input  pcpb_pkg::cmd_t               head,
	input  logic                         head_valid,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pcpb_pkg::ADDR_W-1:0]  write_address,
	output logic [pcpb_pkg::PIX_W-1:0]   write_pixel,
	output logic                         is_write,
	output logic                         last_of_run
);
	import pcpb_pkg::*;

	logic [DUPN_W-1:0] dx_q;
	logic [DUPN_W-1:0] dy_q;
	logic [OFF_W-1:0]  row_off_q;

	logic              ov_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PIX_W-1:0]  pix_q;
	logic              wr_q;
	logic              last_q;

	logic              adv;
	logic              emit;
	logic              last_x;
	logic              last_y;
	logic [ADDR_W-1:0] addr;

	assign adv = !ov_q || out_ready;
	assign emit = head_valid && adv;
	assign last_x = (dx_q == (cfg.dup_x - DUPN_W'(1)));
	assign last_y = (dy_q == (cfg.dup_y - DUPN_W'(1)));
	assign pop = emit && (head.is_end || (last_x && last_y));
	assign addr = head.base + ADDR_W'(row_off_q) + ADDR_W'(dx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0;
			dy_q <= '0;
			row_off_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= head_valid;
			end
			if (emit && !head.is_end) begin
				if (last_x) begin
					dx_q <= '0;
					if (last_y) begin
						dy_q <= '0;
						row_off_q <= '0;
					end else begin
						dy_q <= dy_q + DUPN_W'(1);
						row_off_q <= row_off_q + OFF_W'(cfg.line_width);
					end
				end else begin
					dx_q <= dx_q + DUPN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q <= head.is_end ? '0 : addr;
			pix_q <= head.is_end ? '0 : head.pixel;
			wr_q <= !head.is_end;
			last_q <= head.is_end || (last_x && last_y);
		end
	end

	assign out_valid = ov_q;
	assign write_address = addr_q;
	assign write_pixel = pix_q;
	assign is_write = wr_q;
	assign last_of_run = last_q;

endmodule
